@@ hdl/gpf_pkg.sv @@
`timescale 1ns / 1ps

package gpf_pkg;

  // default width of the number to decompose
  localparam int VALUE_WIDTH_DEF = 20;

  // datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SEL_LO,
    OP_SEL_HI,
    OP_DIV_START,
    OP_D_INC,
    OP_STEP,
    OP_EMIT_HIT,
    OP_EMIT_MISS
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SMALL,
    C_N_LT2,
    C_DSQ_GT_N,
    C_DIV_BUSY,
    C_REM_ZERO,
    C_WHICH_HI,
    C_LO_IS2,
    C_OUT_FULL
  } cond_t;

  typedef logic [4:0] pc_t;

  // microcode step addresses
  localparam pc_t ST_WAIT      = 5'd0;
  localparam pc_t ST_RANGE     = 5'd1;
  localparam pc_t ST_PICK_LO   = 5'd2;
  localparam pc_t ST_PTEST     = 5'd3;
  localparam pc_t ST_PLOOP     = 5'd4;
  localparam pc_t ST_DIV       = 5'd5;
  localparam pc_t ST_DIV_WAIT  = 5'd6;
  localparam pc_t ST_DIV_CHK   = 5'd7;
  localparam pc_t ST_NEXT_D    = 5'd8;
  localparam pc_t ST_PRIME     = 5'd9;
  localparam pc_t ST_PICK_HI   = 5'd10;
  localparam pc_t ST_COMPOSITE = 5'd11;
  localparam pc_t ST_STEP      = 5'd12;
  localparam pc_t ST_HIT       = 5'd13;
  localparam pc_t ST_HIT_END   = 5'd14;
  localparam pc_t ST_MISS      = 5'd15;
  localparam pc_t ST_MISS_END  = 5'd16;

  // one control word: operation, jump condition and jump target
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic in_ready;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic under_four;
    logic n_lt2;
    logic dsq_gt_n;
    logic div_busy;
    logic rem_zero;
    logic which_hi;
    logic lo_is2;
    logic out_full;
  } status_t;

  // the microprogram
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    begin
      case (pc)
        ST_WAIT:      w = '{OP_LOAD,      C_NO_INPUT, ST_WAIT};
        ST_RANGE:     w = '{OP_NOP,       C_SMALL,    ST_MISS};
        ST_PICK_LO:   w = '{OP_SEL_LO,    C_NEVER,    ST_WAIT};
        ST_PTEST:     w = '{OP_NOP,       C_N_LT2,    ST_COMPOSITE};
        ST_PLOOP:     w = '{OP_NOP,       C_DSQ_GT_N, ST_PRIME};
        ST_DIV:       w = '{OP_DIV_START, C_NEVER,    ST_WAIT};
        ST_DIV_WAIT:  w = '{OP_NOP,       C_DIV_BUSY, ST_DIV_WAIT};
        ST_DIV_CHK:   w = '{OP_NOP,       C_REM_ZERO, ST_COMPOSITE};
        ST_NEXT_D:    w = '{OP_D_INC,     C_ALWAYS,   ST_PLOOP};
        ST_PRIME:     w = '{OP_NOP,       C_WHICH_HI, ST_HIT};
        ST_PICK_HI:   w = '{OP_SEL_HI,    C_ALWAYS,   ST_PTEST};
        ST_COMPOSITE: w = '{OP_NOP,       C_LO_IS2,   ST_MISS};
        ST_STEP:      w = '{OP_STEP,      C_ALWAYS,   ST_PICK_LO};
        ST_HIT:       w = '{OP_EMIT_HIT,  C_OUT_FULL, ST_HIT};
        ST_HIT_END:   w = '{OP_NOP,       C_ALWAYS,   ST_WAIT};
        ST_MISS:      w = '{OP_EMIT_MISS, C_OUT_FULL, ST_MISS};
        ST_MISS_END:  w = '{OP_NOP,       C_ALWAYS,   ST_WAIT};
        default:      w = '{OP_NOP,       C_ALWAYS,   ST_WAIT};
      endcase
      return w;
    end
  endfunction

endpackage

@@ hdl/gpf_ifs.sv @@
`timescale 1ns / 1ps

// input channel: one number per transaction
interface gpf_in_if #(
  parameter int VALUE_WIDTH = gpf_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

// output channel: one decomposition per transaction
interface gpf_out_if #(
  parameter int VALUE_WIDTH = gpf_pkg::VALUE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [VALUE_WIDTH:0] even_value;
  logic [VALUE_WIDTH:0] lower_prime;
  logic [VALUE_WIDTH:0] upper_prime;
  logic                 found;

  modport source (output valid, output even_value, output lower_prime,
                  output upper_prime, output found, input ready);
  modport sink   (input valid, input even_value, input lower_prime,
                  input upper_prime, input found, output ready);
endinterface

@@ hdl/gpf_rem.sv @@
`timescale 1ns / 1ps

// restoring remainder unit, one dividend bit per cycle
module gpf_rem #(
  parameter int NW = 21,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          rem_zero
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] shreg;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // bring in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, shreg[NW-1]};
    diff  = trial - {1'b0, divisor};
  end

  // bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  // partial remainder and dividend shift register
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[NW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[DW-1:0];
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

  assign busy     = (cnt != '0);
  assign rem_zero = (rem == '0);

endmodule

@@ hdl/gpf_seq.sv @@
`timescale 1ns / 1ps

// microcode sequencer: step counter, control store and jump logic
module gpf_seq (
  input  logic             clk,
  input  logic             rst,
  input  gpf_pkg::status_t status,
  output gpf_pkg::ctrl_t   ctrl
);

  gpf_pkg::pc_t    pc;
  gpf_pkg::pc_t    pc_next;
  gpf_pkg::ucode_t word;
  logic            take;

  assign word = gpf_pkg::ucode_rom(pc);

  // jump condition select
  always_comb begin
    case (word.cond)
      gpf_pkg::C_NEVER:    take = 1'b0;
      gpf_pkg::C_ALWAYS:   take = 1'b1;
      gpf_pkg::C_NO_INPUT: take = !status.in_valid;
      gpf_pkg::C_SMALL:    take = status.under_four;
      gpf_pkg::C_N_LT2:    take = status.n_lt2;
      gpf_pkg::C_DSQ_GT_N: take = status.dsq_gt_n;
      gpf_pkg::C_DIV_BUSY: take = status.div_busy;
      gpf_pkg::C_REM_ZERO: take = status.rem_zero;
      gpf_pkg::C_WHICH_HI: take = status.which_hi;
      gpf_pkg::C_LO_IS2:   take = status.lo_is2;
      gpf_pkg::C_OUT_FULL: take = status.out_full;
      default:             take = 1'b1;
    endcase
    pc_next = take ? word.target : pc + gpf_pkg::pc_t'(1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= gpf_pkg::ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.op       = word.op;
  assign ctrl.in_ready = (pc == gpf_pkg::ST_WAIT);

endmodule

@@ hdl/gpf_datapath.sv @@
`timescale 1ns / 1ps

// candidate pair registers, divisor walk and result register
module gpf_datapath #(
  parameter int VALUE_WIDTH = gpf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gpf_pkg::ctrl_t         ctrl,
  output gpf_pkg::status_t       status,
  input  logic                   in_valid,
  input  logic [VALUE_WIDTH-1:0] number_in,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [VALUE_WIDTH:0]   even_value,
  output logic [VALUE_WIDTH:0]   lower_prime,
  output logic [VALUE_WIDTH:0]   upper_prime,
  output logic                   found
);

  localparam int VW = VALUE_WIDTH + 1;
  localparam int DW = VALUE_WIDTH / 2 + 2;
  localparam int SW = VALUE_WIDTH + 3;

  logic [VW-1:0] even;
  logic [VW-1:0] lo;
  logic [VW-1:0] hi;
  logic [VW-1:0] n;
  logic [DW-1:0] d;
  logic [SW-1:0] dsq;
  logic          which_hi;
  logic [VW-1:0] even_in;
  logic          div_busy;
  logic          rem_zero;
  logic          out_full;
  logic          emit_ok;
  logic          div_start;

  assign even_in   = {1'b0, number_in} + VW'(number_in[0]);
  assign out_full  = out_valid && !out_ready;
  assign emit_ok   = !out_full;
  assign div_start = (ctrl.op == gpf_pkg::OP_DIV_START);

  // trial division remainder n % d
  gpf_rem #(
    .NW(VW),
    .DW(DW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (d),
    .busy     (div_busy),
    .rem_zero (rem_zero)
  );

  // working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      gpf_pkg::OP_LOAD: begin
        if (in_valid) begin
          even <= even_in;
          lo   <= even_in >> 1;
          hi   <= even_in >> 1;
        end
      end
      gpf_pkg::OP_SEL_LO: begin
        n        <= lo;
        d        <= DW'(2);
        dsq      <= SW'(4);
        which_hi <= 1'b0;
      end
      gpf_pkg::OP_SEL_HI: begin
        n        <= hi;
        d        <= DW'(2);
        dsq      <= SW'(4);
        which_hi <= 1'b1;
      end
      gpf_pkg::OP_D_INC: begin
        // (d+1)^2 = d^2 + 2d + 1
        d   <= d + DW'(1);
        dsq <= dsq + SW'({d, 1'b1});
      end
      gpf_pkg::OP_STEP: begin
        lo <= lo - VW'(1);
        hi <= hi + VW'(1);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == gpf_pkg::OP_EMIT_HIT && emit_ok) begin
      out_valid <= 1'b1;
    end else if (ctrl.op == gpf_pkg::OP_EMIT_MISS && emit_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == gpf_pkg::OP_EMIT_HIT && emit_ok) begin
      even_value  <= even;
      lower_prime <= lo;
      upper_prime <= hi;
      found       <= 1'b1;
    end else if (ctrl.op == gpf_pkg::OP_EMIT_MISS && emit_ok) begin
      even_value  <= even;
      lower_prime <= '0;
      upper_prime <= '0;
      found       <= 1'b0;
    end
  end

  // flags for the sequencer
  always_comb begin
    status.in_valid   = in_valid;
    status.under_four = (even < VW'(4));
    status.n_lt2      = (n < VW'(2));
    status.dsq_gt_n   = (dsq > SW'(n));
    status.div_busy   = div_busy;
    status.rem_zero   = rem_zero;
    status.which_hi   = which_hi;
    status.lo_is2     = (lo == VW'(2));
    status.out_full   = out_full;
  end

  // a found pair adds up to the even value
  a_pair_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> ({1'b0, lower_prime} + {1'b0, upper_prime}) == {1'b0, even_value})
    else $error("prime pair does not add up to the even value");

  // lower prime never above upper prime
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> lower_prime <= upper_prime)
    else $error("lower prime above upper prime");

  // a miss carries zero primes
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> lower_prime == '0 && upper_prime == '0)
    else $error("miss result carries nonzero primes");

  // a division never restarts while one is in flight
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("division started while busy");

endmodule

@@ hdl/goldbach_prime_pair_finder_core.sv @@
`timescale 1ns / 1ps
// an even value below 4 gets a miss result straight from the range check; otherwise each half
//   of the pair is tested by the bit-serial remainder unit, dividing by d from 2 upward, one
//   divisor after another, until d*d exceeds it or a divisor leaves no remainder
// throughput: one number at a time; the next is taken after the result is loaded into the free output
//   register (which holds it while the receiver is not ready) and the sequencer is back in its wait step
// reset: synchronous active-high rst returns the sequencer to its wait step and empties the output
module goldbach_prime_pair_finder_core #(
  parameter int VALUE_WIDTH = gpf_pkg::VALUE_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst,
  gpf_in_if.sink  in_ch,
  gpf_out_if.source out_ch
);

  gpf_pkg::ctrl_t   ctrl;
  gpf_pkg::status_t status;

  assign in_ch.ready = ctrl.in_ready;

  // microcode control
  gpf_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // datapath
  gpf_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .in_valid    (in_ch.valid),
    .number_in   (in_ch.number_in),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .even_value  (out_ch.even_value),
    .lower_prime (out_ch.lower_prime),
    .upper_prime (out_ch.upper_prime),
    .found       (out_ch.found)
  );

endmodule

@@ test/goldbach_prime_pair_finder_core_tb.sv @@
`timescale 1ns / 1ps

module goldbach_prime_pair_finder_core_tb;

  localparam int VW            = gpf_pkg::VALUE_WIDTH_DEF;
  localparam int CYCLE_LIMIT   = 40_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 4000;

  // one decomposition as the block reports it
  typedef struct {
    logic [VW:0] even_value;
    logic [VW:0] lower_prime;
    logic [VW:0] upper_prime;
    logic        found;
  } pair_result_t;

  logic clk;
  logic rst;

  gpf_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
  gpf_out_if #(.VALUE_WIDTH(VW)) out_ch ();

  goldbach_prime_pair_finder_core #(
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pair_result_t expected_pairs[$];
  int unsigned  error_count  = 0;
  int unsigned  cycle_count  = 0;
  int unsigned  hold_trigger = 0;
  bit           src_gaps     = 1'b1;
  bit           sink_gaps    = 1'b1;

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // trial division by every d with d*d <= n; 0 and 1 are not prime
  function automatic bit prime_by_trial(input logic [63:0] n);
    logic [63:0] d;
    if (n < 2)
      return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // round up to even, then walk the halves apart until both are prime
  function automatic pair_result_t predict_pair(input logic [VW-1:0] num);
    pair_result_t res;
    logic [63:0]  even_v;
    logic [63:0]  lo;
    even_v          = num;
    even_v          = even_v + num[0];
    res.even_value  = even_v[VW:0];
    res.lower_prime = '0;
    res.upper_prime = '0;
    res.found       = 1'b0;
    if (even_v >= 4 && even_v < (64'd1 << (VW + 1))) begin
      lo = even_v / 2;
      while (lo >= 2 && !res.found) begin
        if (prime_by_trial(lo) && prime_by_trial(even_v - lo)) begin
          res.lower_prime = lo[VW:0];
          res.upper_prime = even_v[VW:0] - lo[VW:0];
          res.found       = 1'b1;
        end
        lo = lo - 1;
      end
    end
    return res;
  endfunction

  // offer one number until the block takes it, then maybe idle
  task automatic send_number(input logic [VW-1:0] num);
    in_ch.valid     <= 1'b1;
    in_ch.number_in <= num;
    do
      @(posedge clk);
    while (in_ch.ready !== 1'b1);
    expected_pairs.push_back(predict_pair(num));
    if (src_gaps && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // mostly small values, some mid-sized, rarely the full range
  function automatic logic [VW-1:0] pick_number();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 2)
      v = $urandom;
    else if (r < 20)
      v = $urandom_range(0, 8191);
    else
      v = $urandom_range(0, 1023);
    return v[VW-1:0];
  endfunction

  // sink side: random stalls, plus a long hold-off on request
  initial begin : sink_ready
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned burst_left;
    hold_seen  = 0;
    hold_left  = 0;
    burst_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(1, 4) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    pair_result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_pairs.size() == 0) begin
        $error("unexpected result: even_value %0d found %0b",
               out_ch.even_value, out_ch.found);
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_ch.even_value !== want.even_value) begin
          $error("even_value: expected %0d, got %0d", want.even_value, out_ch.even_value);
          error_count++;
        end
        if (out_ch.lower_prime !== want.lower_prime) begin
          $error("lower_prime: expected %0d, got %0d", want.lower_prime, out_ch.lower_prime);
          error_count++;
        end
        if (out_ch.upper_prime !== want.upper_prime) begin
          $error("upper_prime: expected %0d, got %0d", want.upper_prime, out_ch.upper_prime);
          error_count++;
        end
        if (out_ch.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_ch.found);
          error_count++;
        end
      end
    end
  end

  // values with no pair, the smallest pairs and odd rounding
  task automatic test_small_values();
    int unsigned v;
    for (v = 0; v <= 10; v++)
      send_number(v[VW-1:0]);
    send_number(VW'(12));
    send_number(VW'(97));
  endtask

  // all-ones input rounds up past the input width
  task automatic test_largest_values();
    send_number({VW{1'b1}});
    send_number({{(VW-1){1'b1}}, 1'b0});
    send_number({1'b1, {(VW-2){1'b0}}, 1'b1} >> 1);
  endtask

  task automatic test_random_numbers();
    int unsigned i;
    for (i = 0; i < 105; i++)
      send_number(pick_number());
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_output_stall();
    int unsigned i;
    src_gaps     <= 1'b0;
    hold_trigger <= hold_trigger + 1;
    for (i = 0; i < 10; i++)
      send_number(VW'($urandom_range(0, 200)));
    src_gaps <= 1'b1;
  endtask

  // closing stretch with no idling on either side
  task automatic test_back_to_back();
    int unsigned i;
    @(posedge clk);
    src_gaps  <= 1'b0;
    sink_gaps <= 1'b0;
    for (i = 0; i < 20; i++)
      send_number(VW'($urandom_range(0, 511)));
  endtask

  initial begin : run_tests
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.number_in <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_small_values();
    test_largest_values();
    test_random_numbers();
    test_output_stall();
    test_back_to_back();

    // drain, then give any stray transaction time to show up
    in_ch.valid <= 1'b0;
    while (expected_pairs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/gpf_pkg.sv
hdl/gpf_ifs.sv
hdl/gpf_rem.sv
hdl/gpf_seq.sv
hdl/gpf_datapath.sv
hdl/goldbach_prime_pair_finder_core.sv
test/goldbach_prime_pair_finder_core_tb.sv
